### hdl/i2cbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Shared types, command codes and the sequence length table.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

	localparam int unsigned IDX_W  = 5;
	localparam int unsigned WAIT_W = 16;

	localparam logic [WAIT_W-1:0] HALF_PERIOD_RESET = 16'd10;

	// Operation codes as they arrive on the command word.
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_RACK  = 3'd6;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_SACK  = 3'd5,
		CMD_RACK  = 3'd6
	} cmd_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} result_t;

	// Number of pin actions in each command sequence.
	function automatic logic [IDX_W-1:0] seq_len(cmd_t c);
		logic [IDX_W-1:0] n;
		case (c)
			CMD_START: n = 5'd4;
			CMD_STOP:  n = 5'd3;
			CMD_WRITE: n = 5'd24;
			CMD_READ:  n = 5'd25;
			CMD_SACK:  n = 5'd3;
			CMD_RACK:  n = 5'd4;
			default:   n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

### hdl/i2cbm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master command channel
// One word per tick: command, write data, ack level and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cbm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] tx_byte;
	logic       ack_level;
	logic       sda_sample;

	modport source (output valid, output operation, output tx_byte, output ack_level,
		output sda_sample, input ready);
	modport sink (input valid, input operation, input tx_byte, input ack_level,
		input sda_sample, output ready);
endinterface

### hdl/i2cbm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master result channel
// One word per tick: pin levels, status and received data.
// ----------------------------------------------------------------------------
interface i2cbm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_drive;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	modport source (output valid, output scl_drive, output sda_drive, output busy_res,
		output done_res, output rx_byte, output ack_seen, input ready);
	modport sink (input valid, input scl_drive, input sda_drive, input busy_res,
		input done_res, input rx_byte, input ack_seen, output ready);
endinterface

### hdl/i2cbm_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master configuration channel
// Write-only channel for the half period register.
// ----------------------------------------------------------------------------
interface i2cbm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/i2cbm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master sequencer
// Holds the command state and plays one tick per accepted word.
// ----------------------------------------------------------------------------
module i2cbm_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [2:0]                    operation,
	input  logic [7:0]                    tx_byte,
	input  logic                          ack_level,
	input  logic                          sda_sample,
	input  logic [i2cbm_pkg::WAIT_W-1:0]  hold,
	output i2cbm_pkg::result_t            res
);

	i2cbm_pkg::cmd_t cmd_q, cmd_n, act_cmd;
	logic [i2cbm_pkg::IDX_W-1:0]  idx_q, idx_n, act_idx;
	logic [i2cbm_pkg::WAIT_W-1:0] wc_q, wc_n, wc_dec;
	logic [1:0] phase_q, phase_n, act_phase;
	logic [7:0] shift_q, shift_n, act_shift;
	logic [7:0] rx_q, rx_n;
	logic       ack_q, ack_n;
	logic       scl_q, scl_n, sda_q, sda_n;
	logic       start_ok, finish, do_act;

	// Next command state and timing.
	always_comb begin
		start_ok = (cmd_q == i2cbm_pkg::CMD_IDLE) && (operation >= i2cbm_pkg::OP_START)
			&& (operation <= i2cbm_pkg::OP_RACK);
		wc_dec = (wc_q != '0) ? wc_q - 1'b1 : wc_q;
		finish = (cmd_q != i2cbm_pkg::CMD_IDLE) && (wc_dec == '0)
			&& (idx_q >= i2cbm_pkg::seq_len(cmd_q));
		do_act = start_ok || ((cmd_q != i2cbm_pkg::CMD_IDLE) && (wc_dec == '0) && !finish);

		act_cmd   = start_ok ? i2cbm_pkg::cmd_t'(operation) : cmd_q;
		act_idx   = start_ok ? '0 : idx_q;
		act_phase = start_ok ? 2'd0 : phase_q;
		if (start_ok) begin
			if (operation == 3'(i2cbm_pkg::CMD_WRITE)) begin
				act_shift = tx_byte;
			end else if (operation == 3'(i2cbm_pkg::CMD_SACK)) begin
				act_shift = {7'd0, ack_level};
			end else begin
				act_shift = 8'd0;
			end
		end else begin
			act_shift = shift_q;
		end

		if (finish) begin
			cmd_n = i2cbm_pkg::CMD_IDLE;
			idx_n = '0;
		end else begin
			cmd_n = act_cmd;
			idx_n = do_act ? act_idx + 1'b1 : idx_q;
		end
		wc_n = do_act ? hold : wc_dec;

		// Bit phase of write and read byte; the leading release of a read
		// does not advance it.
		phase_n = phase_q;
		if (do_act) begin
			if (act_cmd == i2cbm_pkg::CMD_READ && act_idx == '0) begin
				phase_n = 2'd0;
			end else begin
				phase_n = (act_phase == 2'd2) ? 2'd0 : act_phase + 2'd1;
			end
		end

		rx_n = (finish && cmd_q == i2cbm_pkg::CMD_READ) ? shift_q : rx_q;
	end

	// Pin actions.
	always_comb begin
		scl_n   = scl_q;
		sda_n   = sda_q;
		ack_n   = ack_q;
		shift_n = act_shift;
		if (do_act) begin
			unique case (act_cmd)
				i2cbm_pkg::CMD_START: begin
					if (act_idx == 5'd0) sda_n = 1'b1;
					else if (act_idx == 5'd1) scl_n = 1'b1;
					else if (act_idx == 5'd2) sda_n = 1'b0;
					else scl_n = 1'b0;
				end
				i2cbm_pkg::CMD_STOP: begin
					if (act_idx == 5'd0) sda_n = 1'b0;
					else if (act_idx == 5'd1) scl_n = 1'b1;
					else sda_n = 1'b1;
				end
				i2cbm_pkg::CMD_WRITE: begin
					if (act_phase == 2'd0) begin
						sda_n   = act_shift[7];
						shift_n = {act_shift[6:0], 1'b0};
					end else if (act_phase == 2'd1) begin
						scl_n = 1'b1;
					end else begin
						scl_n = 1'b0;
					end
				end
				i2cbm_pkg::CMD_READ: begin
					if (act_idx == 5'd0) sda_n = 1'b1;
					else if (act_phase == 2'd0) scl_n = 1'b1;
					else if (act_phase == 2'd1) shift_n = {act_shift[6:0], sda_sample};
					else scl_n = 1'b0;
				end
				i2cbm_pkg::CMD_SACK: begin
					if (act_idx == 5'd0) sda_n = act_shift[0];
					else if (act_idx == 5'd1) scl_n = 1'b1;
					else scl_n = 1'b0;
				end
				i2cbm_pkg::CMD_RACK: begin
					if (act_idx == 5'd0) sda_n = 1'b1;
					else if (act_idx == 5'd1) scl_n = 1'b1;
					else if (act_idx == 5'd2) ack_n = sda_sample;
					else scl_n = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cbm_pkg::CMD_IDLE;
			idx_q   <= '0;
			wc_q    <= '0;
			phase_q <= 2'd0;
			shift_q <= 8'd0;
			rx_q    <= 8'd0;
			ack_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (accept) begin
			cmd_q   <= cmd_n;
			idx_q   <= idx_n;
			wc_q    <= wc_n;
			phase_q <= phase_n;
			shift_q <= shift_n;
			rx_q    <= rx_n;
			ack_q   <= ack_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
		end
	end

	always_comb begin
		res.scl_drive = scl_n;
		res.sda_drive = sda_n;
		res.busy_res  = (cmd_n != i2cbm_pkg::CMD_IDLE);
		res.done_res  = finish;
		res.rx_byte   = rx_n;
		res.ack_seen  = ack_n;
	end

	a_idle_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q == i2cbm_pkg::CMD_IDLE) |-> (wc_q == '0 && idx_q == '0))
		else $error("wait counter or index left over while idle");

	a_busy_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q != i2cbm_pkg::CMD_IDLE) |-> (wc_q != '0))
		else $error("busy with an empty wait counter");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q != i2cbm_pkg::CMD_IDLE) |-> (idx_q <= i2cbm_pkg::seq_len(cmd_q)))
		else $error("action index ran past the sequence");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && finish) |=> (cmd_q == i2cbm_pkg::CMD_IDLE))
		else $error("command still active after finishing");

endmodule

### hdl/i2cbm_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cbm_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  i2cbm_pkg::result_t res,
	output logic               can_load,
	i2cbm_out_if.source        res_out
);

	logic               valid_q;
	i2cbm_pkg::result_t data_q;

	// A new word may enter when the register is empty or is emptied this cycle.
	assign can_load = !valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign res_out.valid     = valid_q;
	assign res_out.scl_drive = data_q.scl_drive;
	assign res_out.sda_drive = data_q.sda_drive;
	assign res_out.busy_res  = data_q.busy_res;
	assign res_out.done_res  = data_q.done_res;
	assign res_out.rx_byte   = data_q.rx_byte;
	assign res_out.ack_seen  = data_q.ack_seen;

endmodule

### hdl/i2c_bit_level_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master
// Plays start, stop, byte write/read and ack commands as SCL/SDA pin levels.
// ----------------------------------------------------------------------------
// Each word on cmd_in is one tick of the bit-timing clock: an optional command
// plus the SDA level sampled on that tick. Every accepted word yields exactly
// one word on res_out with the pin levels to drive, busy and done status, the
// last received byte and the last sampled ack. Commands that arrive while a
// sequence is running are ignored. After each pin action the sequencer waits
// half_period_ticks ticks, which must be written through cfg while the block is
// idle; the block itself does not enforce this. A value of zero counts as one.
// The result word is registered on acceptance and is valid in the next cycle.
// One word is taken per cycle when res_out is not stalled; the sequencer state
// and a single result register set that rate. When the receiver stalls, the
// result register holds its word and cmd_in ready stays low until it is taken.
// The cfg channel is always ready. Reset drives both lines high, returns the
// sequencer to idle and loads a half period of ten ticks.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_unit (
	input  logic         clk,
	input  logic         arst_n,
	i2cbm_in_if.sink     cmd_in,
	i2cbm_out_if.source  res_out,
	i2cbm_cfg_if.sink    cfg
);

	logic [i2cbm_pkg::WAIT_W-1:0] half_period_q;
	logic [i2cbm_pkg::WAIT_W-1:0] hold;
	logic                         accept;
	logic                         can_load;
	i2cbm_pkg::result_t           res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cbm_pkg::HALF_PERIOD_RESET;
		end else if (cfg.valid) begin
			half_period_q <= cfg.data;
		end
	end

	assign hold = (half_period_q == '0) ? i2cbm_pkg::WAIT_W'(1) : half_period_q;

	assign cmd_in.ready = can_load;
	assign accept       = cmd_in.valid && can_load;

	i2cbm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (cmd_in.operation),
		.tx_byte    (cmd_in.tx_byte),
		.ack_level  (cmd_in.ack_level),
		.sda_sample (cmd_in.sda_sample),
		.hold       (hold),
		.res        (res)
	);

	i2cbm_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res      (res),
		.can_load (can_load),
		.res_out  (res_out)
	);

endmodule
